### rtl/glmt_pkg.sv
// Shared types, codes and defaults of the greedy longest-match transliterator.
package glmt_pkg;

  localparam int CP_W          = 21;
  localparam int OP_W          = 2;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 24;
  localparam int KEY_LEN_DEF   = 4;
  localparam int VALUE_LEN_DEF = 4;
  localparam int ENTRIES_DEF   = 64;

  typedef enum logic [OP_W-1:0] {
    OP_TEXT   = 2'd0,
    OP_KEY    = 2'd1,
    OP_VAL    = 2'd2,
    OP_COMMIT = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CP     = 2'd0,
    KIND_END    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LAUNCH,
    S_SEARCH,
    S_VAL,
    S_PASS,
    S_END,
    S_STATUS
  } state_e;

endpackage

### rtl/greedy_longest_match_transliterator.sv
// Top level of the greedy longest-match transliterator: staging, window, value memory, control.
// Key and value characters are staged; a commit searches the table unless staging overflowed.
// A text item runs any due match steps; at end of string the end marker follows them.
// A match step passes one code point through, or emits each value code point on a match;
// a busy result side stretches any emitting cycle.
// Reset clears the table count, longest key, staging, window and control; stores stay as is.
module greedy_longest_match_transliterator #(
  parameter int KEY_LEN   = glmt_pkg::KEY_LEN_DEF,
  parameter int VALUE_LEN = glmt_pkg::VALUE_LEN_DEF,
  parameter int ENTRIES   = glmt_pkg::ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [glmt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // op[1:0], code_point[22:2]
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [glmt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // out_code_point[20:0], status[22:21]
  output logic [glmt_pkg::KIND_W-1:0]          m_axis_tuser   // kind[1:0]
);
  import glmt_pkg::*;

  localparam int KLW = $clog2(KEY_LEN + 1);
  localparam int VLW = $clog2(VALUE_LEN + 1);
  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int RW  = VLW + VALUE_LEN * CP_W;

  state_e                          state_q, state_d;
  logic                            dup_q, dup_d;
  logic                            eos_q, eos_d;
  logic [KLW-1:0]                  fill_q, fill_d;
  logic [KEY_LEN-1:0][CP_W-1:0]    win_q, win_d;
  logic [KLW-1:0]                  longest_q, longest_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [KEY_LEN-1:0][CP_W-1:0]    skey_q, skey_d;
  logic [KLW-1:0]                  skl_q, skl_d;
  logic [VALUE_LEN-1:0][CP_W-1:0]  sval_q, sval_d;
  logic [VLW-1:0]                  svl_q, svl_d;
  logic                            sov_q, sov_d;
  logic [KLW-1:0]                  rlen_q, rlen_d;
  logic [VLW-1:0]                  vcnt_q, vcnt_d;
  status_e                         st_q, st_d;
  logic                            mvalid_q, mvalid_d;
  kind_e                           mkind_q, mkind_d;
  logic [CP_W-1:0]                 mcp_q, mcp_d;
  status_e                         mst_q, mst_d;

  logic                            start, wr_en, out_free, drop_en;
  logic [KLW-1:0]                  drop_n, target;
  logic                            c_done, c_hit;
  logic [KLW-1:0]                  c_len;
  logic [IW-1:0]                   c_idx;
  logic [KEY_LEN-1:0][CP_W-1:0]    q_chars;
  logic [KLW-1:0]                  q_len;
  logic [RW-1:0]                   vmem [ENTRIES];
  logic [RW-1:0]                   rdata_q;
  logic [VLW-1:0]                  rd_vlen;
  logic [VALUE_LEN-1:0][CP_W-1:0]  rd_chars;
  logic [CP_W-1:0]                 rd_char;
  op_e                             in_op;
  logic [CP_W-1:0]                 in_cp;

  assign in_op = op_e'(s_axis_tdata[OP_W-1:0]);
  assign in_cp = s_axis_tdata[OP_W +: CP_W];

  // Query is the staged key during a commit, else the window
  assign q_chars = dup_q ? skey_q : win_q;
  assign q_len   = dup_q ? skl_q  : fill_q;

  glmt_chain #(
    .KEY_LEN(KEY_LEN),
    .ENTRIES(ENTRIES),
    .KLW    (KLW),
    .IW     (IW)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .q_dup_i  (dup_q),
    .q_chars_i(q_chars),
    .q_len_i  (q_len),
    .done_o   (c_done),
    .hit_o    (c_hit),
    .len_o    (c_len),
    .idx_o    (c_idx),
    .wr_en_i  (wr_en),
    .wr_idx_i (count_q[IW-1:0]),
    .wr_key_i (skey_q),
    .wr_klen_i(skl_q)
  );

  // Value memory: one row per entry, read at the token's winning index
  always_ff @(posedge clk_i) begin
    if (wr_en) vmem[count_q[IW-1:0]] <= {svl_q, sval_q};
    rdata_q <= vmem[c_idx];
  end

  assign rd_vlen  = rdata_q[RW-1 -: VLW];
  assign rd_chars = rdata_q[VALUE_LEN*CP_W-1:0];

  always_comb begin
    rd_char = '0;
    for (int i = 0; i < VALUE_LEN; i++) begin
      if (VLW'(i) == vcnt_q) rd_char = rd_chars[i];
    end
  end

  assign target   = (longest_q == '0) ? KLW'(1) : longest_q;
  assign out_free = !mvalid_q || m_axis_tready;

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    dup_d     = dup_q;
    eos_d     = eos_q;
    fill_d    = fill_q;
    win_d     = win_q;
    longest_d = longest_q;
    count_d   = count_q;
    skey_d    = skey_q;
    skl_d     = skl_q;
    sval_d    = sval_q;
    svl_d     = svl_q;
    sov_d     = sov_q;
    rlen_d    = rlen_q;
    vcnt_d    = vcnt_q;
    st_d      = st_q;
    mvalid_d  = mvalid_q && !m_axis_tready;
    mkind_d   = mkind_q;
    mcp_d     = mcp_q;
    mst_d     = mst_q;
    start     = 1'b0;
    wr_en     = 1'b0;
    drop_en   = 1'b0;
    drop_n    = '0;
    s_axis_tready = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (in_op)
            OP_KEY: begin
              if (skl_q < KLW'(KEY_LEN)) begin
                for (int i = 0; i < KEY_LEN; i++) begin
                  if (KLW'(i) == skl_q) skey_d[i] = in_cp;
                end
                skl_d = skl_q + KLW'(1);
              end else begin
                sov_d = 1'b1;
              end
            end
            OP_VAL: begin
              if (svl_q < VLW'(VALUE_LEN)) begin
                for (int i = 0; i < VALUE_LEN; i++) begin
                  if (VLW'(i) == svl_q) sval_d[i] = in_cp;
                end
                svl_d = svl_q + VLW'(1);
              end else begin
                sov_d = 1'b1;
              end
            end
            OP_COMMIT: begin
              if (sov_q) begin
                st_d    = ST_TOO_LONG;
                state_d = S_STATUS;
              end else begin
                dup_d   = 1'b1;
                state_d = S_LAUNCH;
              end
            end
            default: begin
              if (fill_q < KLW'(KEY_LEN)) begin
                for (int i = 0; i < KEY_LEN; i++) begin
                  if (KLW'(i) == fill_q) win_d[i] = in_cp;
                end
                fill_d = fill_q + KLW'(1);
              end
              eos_d   = s_axis_tlast;
              state_d = S_CHECK;
            end
          endcase
        end
      end
      S_CHECK: begin
        dup_d = 1'b0;
        if (eos_q) begin
          state_d = (fill_q != '0) ? S_LAUNCH : S_END;
        end else begin
          state_d = (fill_q >= target) ? S_LAUNCH : S_IDLE;
        end
      end
      S_LAUNCH: begin
        start   = 1'b1;
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (c_done) begin
          if (!dup_q) begin
            rlen_d  = c_len;
            vcnt_d  = '0;
            state_d = c_hit ? S_VAL : S_PASS;
          end else begin
            state_d = S_STATUS;
            if (c_hit) begin
              st_d = ST_DUP;
              if (skl_q > longest_q) longest_d = skl_q;
            end else if (count_q == CW'(ENTRIES)) begin
              st_d = ST_FULL;
            end else begin
              st_d    = ST_STORED;
              wr_en   = 1'b1;
              count_d = count_q + CW'(1);
              if (skl_q > longest_q) longest_d = skl_q;
            end
          end
        end
      end
      S_VAL: begin
        if (vcnt_q < rd_vlen) begin
          if (out_free) begin
            mvalid_d = 1'b1;
            mkind_d  = KIND_CP;
            mcp_d    = rd_char;
            mst_d    = ST_STORED;
            vcnt_d   = vcnt_q + VLW'(1);
          end
        end else begin
          drop_en = 1'b1;
          drop_n  = rlen_q;
          state_d = S_CHECK;
        end
      end
      S_PASS: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mkind_d  = KIND_CP;
          mcp_d    = win_q[0];
          mst_d    = ST_STORED;
          drop_en  = 1'b1;
          drop_n   = KLW'(1);
          state_d  = S_CHECK;
        end
      end
      S_END: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mkind_d  = KIND_END;
          mcp_d    = '0;
          mst_d    = ST_STORED;
          state_d  = S_IDLE;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mkind_d  = KIND_STATUS;
          mcp_d    = '0;
          mst_d    = st_q;
          skl_d    = '0;
          svl_d    = '0;
          sov_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Drop consumed characters from the window front
    if (drop_en) begin
      for (int i = 0; i < KEY_LEN; i++) begin
        for (int j = 0; j < KEY_LEN; j++) begin
          if (j == i + int'(drop_n)) win_d[i] = win_q[j];
        end
      end
      fill_d = (drop_n > fill_q) ? '0 : fill_q - drop_n;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dup_q     <= 1'b0;
      eos_q     <= 1'b0;
      fill_q    <= '0;
      longest_q <= '0;
      count_q   <= '0;
      skl_q     <= '0;
      svl_q     <= '0;
      sov_q     <= 1'b0;
      mvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      dup_q     <= dup_d;
      eos_q     <= eos_d;
      fill_q    <= fill_d;
      longest_q <= longest_d;
      count_q   <= count_d;
      skl_q     <= skl_d;
      svl_q     <= svl_d;
      sov_q     <= sov_d;
      mvalid_q  <= mvalid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    win_q   <= win_d;
    skey_q  <= skey_d;
    sval_q  <= sval_d;
    rlen_q  <= rlen_d;
    vcnt_q  <= vcnt_d;
    st_q    <= st_d;
    mkind_q <= mkind_d;
    mcp_q   <= mcp_d;
    mst_q   <= mst_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tuser  = mkind_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - CP_W - STATUS_W){1'b0}}, mst_q, mcp_q};

endmodule

### rtl/glmt_cell.sv
// One table entry: holds a key, compares it to the query and updates the passing best match.
module glmt_cell #(
  parameter int KEY_LEN = glmt_pkg::KEY_LEN_DEF,
  parameter int KLW     = 3,
  parameter int IW      = 6,
  parameter int INDEX   = 0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     q_dup_i,
  input  logic [KEY_LEN-1:0][glmt_pkg::CP_W-1:0]   q_chars_i,
  input  logic [KLW-1:0]                           q_len_i,
  input  logic                                     go_i,
  input  logic                                     hit_i,
  input  logic [KLW-1:0]                           len_i,
  input  logic [IW-1:0]                            idx_i,
  output logic                                     go_o,
  output logic                                     hit_o,
  output logic [KLW-1:0]                           len_o,
  output logic [IW-1:0]                            idx_o,
  input  logic                                     wr_en_i,
  input  logic [IW-1:0]                            wr_idx_i,
  input  logic [KEY_LEN-1:0][glmt_pkg::CP_W-1:0]   wr_key_i,
  input  logic [KLW-1:0]                           wr_klen_i
);
  import glmt_pkg::*;

  logic                          valid_q;
  logic [KEY_LEN-1:0][CP_W-1:0]  key_q;
  logic [KLW-1:0]                klen_q;
  logic                          go_q, hit_q;
  logic [KLW-1:0]                len_q;
  logic [IW-1:0]                 idx_q;
  logic                          same, take;

  // Compare the stored key prefix against the query
  always_comb begin
    same = valid_q;
    for (int i = 0; i < KEY_LEN; i++) begin
      if (KLW'(i) < klen_q && key_q[i] != q_chars_i[i]) same = 1'b0;
    end
    if (q_dup_i) begin
      take = same && klen_q == q_len_i && !hit_i;
    end else begin
      take = same && klen_q != '0 && klen_q <= q_len_i && (!hit_i || klen_q > len_i);
    end
  end

  // Store the entry when addressed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_en_i && wr_idx_i == IW'(INDEX)) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i == IW'(INDEX)) begin
      key_q  <= wr_key_i;
      klen_q <= wr_klen_i;
    end
  end

  // Advance the search token to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0;
    end else begin
      go_q <= go_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_i | take;
    len_q <= take ? klen_q : len_i;
    idx_q <= take ? IW'(INDEX) : idx_i;
  end

  assign go_o  = go_q;
  assign hit_o = hit_q;
  assign len_o = len_q;
  assign idx_o = idx_q;

endmodule

### rtl/glmt_chain.sv
// Row of key cells through which a search token travels one cell per cycle.
module glmt_chain #(
  parameter int KEY_LEN = glmt_pkg::KEY_LEN_DEF,
  parameter int ENTRIES = glmt_pkg::ENTRIES_DEF,
  parameter int KLW     = 3,
  parameter int IW      = 6
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic                                     q_dup_i,
  input  logic [KEY_LEN-1:0][glmt_pkg::CP_W-1:0]   q_chars_i,
  input  logic [KLW-1:0]                           q_len_i,
  output logic                                     done_o,
  output logic                                     hit_o,
  output logic [KLW-1:0]                           len_o,
  output logic [IW-1:0]                            idx_o,
  input  logic                                     wr_en_i,
  input  logic [IW-1:0]                            wr_idx_i,
  input  logic [KEY_LEN-1:0][glmt_pkg::CP_W-1:0]   wr_key_i,
  input  logic [KLW-1:0]                           wr_klen_i
);
  import glmt_pkg::*;

  logic           go_w  [ENTRIES:0];
  logic           hit_w [ENTRIES:0];
  logic [KLW-1:0] len_w [ENTRIES:0];
  logic [IW-1:0]  idx_w [ENTRIES:0];

  // Inject a fresh token at the head
  assign go_w[0]  = start_i;
  assign hit_w[0] = 1'b0;
  assign len_w[0] = '0;
  assign idx_w[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    glmt_cell #(
      .KEY_LEN(KEY_LEN),
      .KLW    (KLW),
      .IW     (IW),
      .INDEX  (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .q_dup_i  (q_dup_i),
      .q_chars_i(q_chars_i),
      .q_len_i  (q_len_i),
      .go_i     (go_w[g]),
      .hit_i    (hit_w[g]),
      .len_i    (len_w[g]),
      .idx_i    (idx_w[g]),
      .go_o     (go_w[g+1]),
      .hit_o    (hit_w[g+1]),
      .len_o    (len_w[g+1]),
      .idx_o    (idx_w[g+1]),
      .wr_en_i  (wr_en_i),
      .wr_idx_i (wr_idx_i),
      .wr_key_i (wr_key_i),
      .wr_klen_i(wr_klen_i)
    );
  end

  assign done_o = go_w[ENTRIES];
  assign hit_o  = hit_w[ENTRIES];
  assign len_o  = len_w[ENTRIES];
  assign idx_o  = idx_w[ENTRIES];

endmodule
